[rtl/lpht_pkg.sv]
package lpht_pkg;

  // table geometry
  localparam int TABLE_SLOTS = 2048;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam bit SLOTS_POW2  = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

  // fixed field widths
  localparam int IDX_W   = 11;
  localparam int BREF_W  = 11;
  localparam int CHECK_W = 64;
  localparam int HOME_W  = 32;

  // slot tags
  typedef enum logic [1:0] {
    TAG_NEVER = 2'd0,
    TAG_USED  = 2'd1,
    TAG_FREED = 2'd2
  } tag_t;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_DUP      = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // one slot of the table
  typedef struct packed {
    tag_t                tag;
    logic [CHECK_W-1:0]  checks;
    logic [BREF_W-1:0]   blk;
  } entry_t;

  // access request from control to slot memory
  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    entry_t             wdata;
    logic [SLOT_W-1:0]  raddr;
  } ram_req_t;

  // slot number to the fixed-width index field
  function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+IDX_W-1:0] w;
    w = {{IDX_W{1'b0}}, s};
    return w[IDX_W-1:0];
  endfunction

  // next slot with wrap-around
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

[rtl/lpht_slot_ram.sv]
module lpht_slot_ram (
  input  logic                clk,
  input  lpht_pkg::ram_req_t  req,
  output lpht_pkg::entry_t    rdata
);

  lpht_pkg::entry_t slot_mem_r [lpht_pkg::TABLE_SLOTS];
  lpht_pkg::entry_t rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      slot_mem_r[req.waddr] <= req.wdata;
    end
    rdata_r <= slot_mem_r[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/lpht_ctrl.sv]
module lpht_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  // request item
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_op,
  input  logic [lpht_pkg::HOME_W-1:0]       in_home,
  input  logic [lpht_pkg::CHECK_W-1:0]      in_key,
  input  logic [lpht_pkg::BREF_W-1:0]       in_bref,
  // result item
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [lpht_pkg::IDX_W-1:0]        out_slot,
  output logic [lpht_pkg::BREF_W-1:0]       out_blk,
  // slot memory
  output lpht_pkg::ram_req_t                ram_req,
  input  lpht_pkg::entry_t                  ram_rdata
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MOD   = 6'b000100,
    S_START = 6'b001000,
    S_PROBE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam logic [lpht_pkg::SLOT_W-1:0] LAST_SLOT = lpht_pkg::SLOT_W'(lpht_pkg::TABLE_SLOTS - 1);
  localparam logic [lpht_pkg::SLOT_W:0]   SLOTS_EXT = (lpht_pkg::SLOT_W + 1)'(lpht_pkg::TABLE_SLOTS);

  state_t                           state_r, state_nxt;
  logic [lpht_pkg::SLOT_W-1:0]      clr_r, clr_nxt;
  logic [lpht_pkg::SLOT_W-1:0]      p_r, p_nxt;
  logic [lpht_pkg::SLOT_W-1:0]      n_r, n_nxt;
  logic [lpht_pkg::SLOT_W-1:0]      free_r, free_nxt;
  logic                             free_vld_r, free_vld_nxt;
  logic [1:0]                       op_r, op_nxt;
  logic [lpht_pkg::CHECK_W-1:0]     key_r, key_nxt;
  logic [lpht_pkg::BREF_W-1:0]      bref_r, bref_nxt;
  logic [lpht_pkg::HOME_W-1:0]      home_r, home_nxt;
  logic [lpht_pkg::SLOT_W-1:0]      rem_r, rem_nxt;
  logic [2:0]                       mcnt_r, mcnt_nxt;
  logic [1:0]                       res_status_r, res_status_nxt;
  logic [lpht_pkg::IDX_W-1:0]       res_slot_r, res_slot_nxt;
  logic [lpht_pkg::BREF_W-1:0]      res_blk_r, res_blk_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [1:0]                       out_status_r, out_status_nxt;
  logic [lpht_pkg::IDX_W-1:0]       out_slot_r, out_slot_nxt;
  logic [lpht_pkg::BREF_W-1:0]      out_blk_r, out_blk_nxt;

  // probe evaluation
  logic                             is_free, is_hit, is_never, is_last, stop;
  logic                             fok;
  logic [lpht_pkg::SLOT_W-1:0]      fslot;
  logic [lpht_pkg::SLOT_W-1:0]      rem_step;

  // remainder of the top four home bits, one conditional subtract per bit
  always_comb begin
    logic [lpht_pkg::SLOT_W:0] t;
    logic [lpht_pkg::SLOT_W-1:0] r;
    r = rem_r;
    for (int i = 3; i >= 0; i--) begin
      t = {r, home_r[lpht_pkg::HOME_W-4+i]};
      if (t >= SLOTS_EXT) begin
        t = t - SLOTS_EXT;
      end
      r = t[lpht_pkg::SLOT_W-1:0];
    end
    rem_step = r;
  end

  assign is_never = (ram_rdata.tag == lpht_pkg::TAG_NEVER);
  assign is_free  = (ram_rdata.tag != lpht_pkg::TAG_USED);
  assign is_hit   = (ram_rdata.tag == lpht_pkg::TAG_USED) && (ram_rdata.checks == key_r);
  assign is_last  = (n_r == LAST_SLOT);
  assign stop     = is_hit || is_never || is_last;
  assign fok      = free_vld_r || is_free;
  assign fslot    = free_vld_r ? free_r : p_r;

  assign in_ready = (state_r == S_IDLE);

  // next-state and datapath
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    p_nxt          = p_r;
    n_nxt          = n_r;
    free_nxt       = free_r;
    free_vld_nxt   = free_vld_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    bref_nxt       = bref_r;
    home_nxt       = home_r;
    rem_nxt        = rem_r;
    mcnt_nxt       = mcnt_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_blk_nxt    = res_blk_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_blk_nxt    = out_blk_r;
    out_valid_nxt  = out_valid_r;

    ram_req.we     = 1'b0;
    ram_req.waddr  = p_r;
    ram_req.wdata  = '0;
    ram_req.raddr  = p_r;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // sweep all slots to never used after reset
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_r;
        ram_req.wdata = '0;
        clr_nxt       = lpht_pkg::next_slot(clr_r);
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end

      // take a request item
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_op;
          key_nxt  = in_key;
          bref_nxt = in_bref;
          home_nxt = in_home;
          rem_nxt  = '0;
          mcnt_nxt = '0;
          if (lpht_pkg::SLOTS_POW2) begin
            p_nxt     = in_home[lpht_pkg::SLOT_W-1:0];
            state_nxt = S_START;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end

      // home index reduced four bits per cycle
      S_MOD: begin
        rem_nxt  = rem_step;
        home_nxt = {home_r[lpht_pkg::HOME_W-5:0], 4'b0000};
        mcnt_nxt = mcnt_r + 3'd1;
        if (mcnt_r == 3'd7) begin
          p_nxt     = rem_step;
          state_nxt = S_START;
        end
      end

      // read the home slot
      S_START: begin
        ram_req.raddr = p_r;
        n_nxt         = '0;
        free_vld_nxt  = 1'b0;
        state_nxt     = S_PROBE;
      end

      // one slot checked per cycle, next one read ahead
      S_PROBE: begin
        ram_req.raddr = lpht_pkg::next_slot(p_r);
        if (is_free && !free_vld_r) begin
          free_nxt     = p_r;
          free_vld_nxt = 1'b1;
        end
        if (!stop) begin
          p_nxt = lpht_pkg::next_slot(p_r);
          n_nxt = n_r + 1'b1;
        end else begin
          state_nxt = S_DONE;
          if (op_r == lpht_pkg::OP_INSERT) begin
            if (is_hit) begin
              res_status_nxt = lpht_pkg::ST_DUP;
              res_slot_nxt   = lpht_pkg::slot_to_idx(p_r);
              res_blk_nxt    = ram_rdata.blk;
            end else if (fok) begin
              ram_req.we          = 1'b1;
              ram_req.waddr       = fslot;
              ram_req.wdata.tag    = lpht_pkg::TAG_USED;
              ram_req.wdata.checks = key_r;
              ram_req.wdata.blk    = bref_r;
              res_status_nxt      = lpht_pkg::ST_OK;
              res_slot_nxt        = lpht_pkg::slot_to_idx(fslot);
              res_blk_nxt         = bref_r;
            end else begin
              res_status_nxt = lpht_pkg::ST_FULL;
              res_slot_nxt   = '0;
              res_blk_nxt    = '0;
            end
          end else if (is_hit) begin
            res_status_nxt = lpht_pkg::ST_OK;
            res_slot_nxt   = lpht_pkg::slot_to_idx(p_r);
            res_blk_nxt    = ram_rdata.blk;
            // delete leaves a tombstone, keeping the rest of the slot
            if (op_r == lpht_pkg::OP_DELETE) begin
              ram_req.we           = 1'b1;
              ram_req.waddr        = p_r;
              ram_req.wdata.tag    = lpht_pkg::TAG_FREED;
              ram_req.wdata.checks = ram_rdata.checks;
              ram_req.wdata.blk    = ram_rdata.blk;
            end
          end else begin
            res_status_nxt = lpht_pkg::ST_NOTFOUND;
            res_slot_nxt   = '0;
            res_blk_nxt    = '0;
          end
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_blk_nxt    = res_blk_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    n_r          <= n_nxt;
    free_r       <= free_nxt;
    free_vld_r   <= free_vld_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    bref_r       <= bref_nxt;
    home_r       <= home_nxt;
    rem_r        <= rem_nxt;
    mcnt_r       <= mcnt_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_blk_r    <= res_blk_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_blk_r    <= out_blk_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_blk    = out_blk_r;

endmodule

[rtl/linear_probe_hash_table_top.sv]
// flow: a request is accepted in idle; a table size that is not a power of two first reduces the
// home index in a modulo state; the home slot is read, then one slot is probed per cycle
// overlap: a new item is taken only in the idle state, once the done state has moved the result
// to the output register, which it does only when no untaken result is held there
// reset: synchronous active-low rst_n; a clearing pass over all TABLE_SLOTS slots (2048)
// marks every slot never used, no item is accepted until it ends
module linear_probe_hash_table_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // home_index, check_first, check_second, block_ref_in, zero pad
  input  logic [1:0]   in_tuser,   // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // slot_index, block_ref_out, zero pad
  output logic [1:0]   out_tuser   // status
);

  lpht_pkg::ram_req_t                  ram_req;
  lpht_pkg::entry_t                    ram_rdata;
  logic [lpht_pkg::IDX_W-1:0]          out_slot;
  logic [lpht_pkg::BREF_W-1:0]         out_blk;

  lpht_slot_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  lpht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_home    (in_tdata[31:0]),
    .in_key     ({in_tdata[63:32], in_tdata[95:64]}),
    .in_bref    (in_tdata[106:96]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_slot   (out_slot),
    .out_blk    (out_blk),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  assign out_tdata = {2'b00, out_blk, out_slot};

endmodule
